// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, skipped during reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check without the reset qualifier
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/sonp_pkg.sv =====
package sonp_pkg;

	localparam int unsigned ImgW = 4;
	localparam int unsigned MaxImg = 16;
	localparam int unsigned PermW = 64;
	localparam int unsigned IdxW = 4;

	typedef logic [ImgW-1:0] img_t;
	typedef logic [IdxW-1:0] idx_t;

	// controller states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAR   = 6'b000010,
		ST_PIV   = 6'b000100,
		ST_REV   = 6'b001000,
		ST_SWP   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic par_step;
		logic piv_step;
		logic rev_step;
		logic fix_step;
		logic par_init;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic par_done;
		logic odd;
		logic piv_done;
		logic wrap;
		logic rev_done;
	} sts_t;

endpackage

// ===== sv/sonp_stream_if.sv =====
interface sonp_stream_if #(
	parameter int unsigned W = 64
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sonp_out_if.sv =====
interface sonp_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] perm_out;
	logic        wrapped;

	modport source (output valid, output perm_out, output wrapped, input ready);
	modport sink (input valid, input perm_out, input wrapped, output ready);
endinterface

// ===== sv/sonp_datapath.sv =====
module sonp_datapath #(
	parameter int unsigned N = 16
) (
	input  logic               clk,
	input  logic [63:0]        perm_in,
	input  sonp_pkg::cmd_t     cmd,
	output sonp_pkg::sts_t     sts,
	output logic [63:0]        perm_out,
	output logic               wrapped
);
	import sonp_pkg::*;

	localparam idx_t Last = idx_t'(N - 1);
	localparam idx_t Prev = idx_t'(N - 2);

	img_t img_q [MaxImg];
	idx_t i_q;       // outer parity index, also pivot index
	logic par_q;
	logic need_q;
	logic wrap_q;
	idx_t lo_q;
	idx_t hi_q;
	img_t p_q;
	img_t q_q;

	// one row of comparisons against img[i] per parity step
	logic row_par;
	always_comb begin
		row_par = 1'b0;
		for (int j = 0; j < MaxImg; j++) begin
			if (j < N && idx_t'(j) > i_q && img_q[i_q] > img_q[j])
				row_par = ~row_par;
		end
	end

	// successor image search: first image past the pivot bigger than p
	logic found;
	idx_t found_idx;
	always_comb begin
		found = 1'b0;
		found_idx = '0;
		for (int j = MaxImg - 1; j >= 0; j--) begin
			if (j < N && idx_t'(j) > i_q && img_q[j] > p_q) begin
				found = 1'b1;
				found_idx = idx_t'(j);
			end
		end
	end

	// tail length modulo four decides the final fix swap
	logic [IdxW:0] tail_len;
	logic changed;
	assign tail_len = (IdxW+1)'(N - 1) - {1'b0, i_q};
	assign changed = (tail_len[1:0] == 2'd0) || (tail_len[1:0] == 2'd1);

	// status
	assign sts.par_done = (i_q == Prev);
	assign sts.odd = par_q;
	assign sts.piv_done = !(p_q > q_q && i_q != '0);
	assign sts.wrap = p_q > q_q;
	assign sts.rev_done = !(lo_q < hi_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < MaxImg; k++)
				img_q[k] <= (k < N) ? perm_in[4*k +: 4] : '0;
			i_q <= '0;
			par_q <= 1'b0;
			wrap_q <= 1'b0;
		end else if (cmd.par_step) begin
			par_q <= par_q ^ row_par;
			i_q <= i_q + 1'b1;
		end else if (cmd.par_init) begin
			// odd path setup: optional first swap
			if (img_q[Prev] < img_q[Last]) begin
				img_q[Prev] <= img_q[Last];
				img_q[Last] <= img_q[Prev];
				p_q <= img_q[Last];
				q_q <= img_q[Prev];
				need_q <= 1'b0;
			end else begin
				p_q <= img_q[Prev];
				q_q <= img_q[Last];
				need_q <= 1'b1;
			end
			i_q <= Prev;
		end else if (cmd.piv_step) begin
			if (p_q > q_q && i_q != '0) begin
				q_q <= p_q;
				p_q <= img_q[i_q - 1'b1];
				i_q <= i_q - 1'b1;
			end else if (p_q > q_q) begin
				for (int k = 0; k < MaxImg; k++)
					img_q[k] <= (k < N) ? img_t'(k) : '0;
				wrap_q <= 1'b1;
			end else begin
				lo_q <= i_q + 1'b1;
				hi_q <= Last;
			end
		end else if (cmd.rev_step) begin
			img_q[lo_q] <= img_q[hi_q];
			img_q[hi_q] <= img_q[lo_q];
			lo_q <= lo_q + 1'b1;
			hi_q <= hi_q - 1'b1;
		end else if (cmd.fix_step) begin
			// even: plain last swap; odd: successor swap then parity fix
			if (!par_q) begin
				img_q[Prev] <= img_q[Last];
				img_q[Last] <= img_q[Prev];
			end else begin
				logic [MaxImg*ImgW-1:0] tmp;
				tmp = '0;
				for (int k = 0; k < MaxImg; k++)
					tmp[4*k +: 4] = img_q[k];
				if (found) begin
					tmp[4*i_q +: 4] = img_q[found_idx];
					tmp[4*found_idx +: 4] = img_q[i_q];
				end
				if (changed != need_q) begin
					img_t t;
					t = tmp[4*Prev +: 4];
					tmp[4*Prev +: 4] = tmp[4*Last +: 4];
					tmp[4*Last +: 4] = t;
				end
				for (int k = 0; k < MaxImg; k++)
					img_q[k] <= tmp[4*k +: 4];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < MaxImg; k++)
			perm_out[4*k +: 4] = img_q[k];
	end
	assign wrapped = wrap_q;
endmodule

// ===== sv/sonp_ctrl.sv =====
module sonp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  sonp_pkg::sts_t sts,
	output sonp_pkg::cmd_t cmd
);
	import sonp_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_PAR;
				end
			end
			ST_PAR: begin
				cmd.par_step = 1'b1;
				if (sts.par_done)
					state_d = ST_PIV;
			end
			ST_PIV: begin
				// even path goes straight to the fix swap
				if (!sts.odd) begin
					state_d = ST_SWP;
				end else begin
					cmd.par_init = 1'b1;
					state_d = ST_REV;
				end
			end
			ST_REV: begin
				cmd.piv_step = 1'b1;
				if (sts.piv_done)
					state_d = sts.wrap ? ST_OUT : ST_SWP;
			end
			ST_SWP: begin
				if (sts.odd && !sts.rev_done) begin
					cmd.rev_step = 1'b1;
				end else begin
					cmd.fix_step = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end
endmodule

// ===== sv/signed_order_next_permutation.sv =====
// Sign-alternating order next permutation. Takes one request at a time:
// parity is computed one inversion row per cycle; an odd input then walks
// the pivot one position per cycle and reverses the tail one pair per
// cycle, while an even input goes from parity straight to the fix swap.
// The next request can be taken in the cycle after the result is read.
`include "assert_macros.svh"
module signed_order_next_permutation #(
	parameter int unsigned IMAGE_COUNT = 16
) (
	input logic        clk,
	input logic        arst_n,
	sonp_stream_if.sink in_ch,
	sonp_out_if.source  out_ch
);
	import sonp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sonp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sonp_datapath #(.N(IMAGE_COUNT)) u_dp (
		.clk     (clk),
		.perm_in (in_ch.data),
		.cmd     (cmd),
		.sts     (sts),
		.perm_out(out_ch.perm_out),
		.wrapped (out_ch.wrapped)
	);

	`ASSERT_CLK(a_no_overlap, clk, arst_n, !(in_ch.ready && out_ch.valid), "busy overlap")
	`ASSERT_CLK(a_out_after_work, clk, arst_n, $rose(out_ch.valid) |-> !$past(in_ch.ready),
		"result without work")
	`ASSERT_CLK(a_take_starts, clk, arst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready,
		"request not taken")
endmodule
